// File: rtl/core/pvas_pkg.sv
// Package for the polygon vertex angular sort block.
// Sequencer state type, fixed field widths and half-plane class function; no dependencies.
`timescale 1ns / 1ps
package pvas_pkg;
    localparam int CoordW = 16;
    localparam int OffW   = 17;
    typedef enum logic [2:0] {
        ST_LOAD, ST_DIVX, ST_DIVY, ST_SORT_RD, ST_SORT_CMP, ST_EMIT
    } t_state;
    // half-plane class: below axis, positive x axis/origin, above, negative x axis
    localparam logic [1:0] HC_NEG = 2'd0;
    localparam logic [1:0] HC_ZERO = 2'd1;
    localparam logic [1:0] HC_POS = 2'd2;
    localparam logic [1:0] HC_180 = 2'd3;
    function automatic logic [1:0] half_class(input logic signed [OffW-1:0] x,
                                              input logic signed [OffW-1:0] y);
        logic [1:0] c;
        if (y < 0) begin
            c = HC_NEG;
        end else if (y > 0) begin
            c = HC_POS;
        end else if (x >= 0) begin
            c = HC_ZERO;
        end else begin
            c = HC_180;
        end
        return c;
    endfunction
endpackage

// File: rtl/core/polygon_vertex_angular_sort.sv
// Top level of the polygon vertex angular sort block.
// Depends on pvas_pkg (state type, class function).
`timescale 1ns / 1ps
// Vertices load one word per cycle while busy is low. After the word with
// final_vertex set, busy rises and the run for n stored vertices has these steps:
//   - the centroid, x then y, on a shared restoring divider;
//   - an insertion sort of the offsets on one shared cross-product compare.
//     Each vertex costs one read step and then compare steps, each moving one
//     stored offset up, until the vertex finds its place; a closing read step
//     ends the sort;
//   - the emit of the n sorted words.
// Busy falls in the cycle in which the last word sits on the outputs. The
// sorted words leave one per cycle on o_valid with no back-pressure: the
// receiver must take them. Overflowed vertices are dropped and flagged on
// every word of the run.
module polygon_vertex_angular_sort import pvas_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      i_x_coord,
    input  logic signed [15:0]      i_y_coord,
    input  logic                    i_final_vertex,
    output logic                    o_valid,
    output logic signed [16:0]      o_x_offset,
    output logic signed [16:0]      o_y_offset,
    output logic                    o_last_out,
    output logic                    o_overflow
);
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = 22;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic signed [SW-1:0] r_sx, r_sy;
    logic r_ovf;
    // divider
    logic [SW-1:0] r_quo, r_rem;
    logic [4:0]    r_bit;
    logic signed [15:0] r_cx, r_cy;
    // sort indices
    logic [CW-1:0] r_i, r_j;
    logic signed [OffW-1:0] r_vx, r_vy, r_px, r_py;

    // vertex store and sorted store
    logic signed [15:0] m_x [MAX_VERTICES];
    logic signed [15:0] m_y [MAX_VERTICES];
    logic signed [OffW-1:0] s_x [MAX_VERTICES];
    logic signed [OffW-1:0] s_y [MAX_VERTICES];

    logic acc;
    assign busy = (r_state != ST_LOAD);
    assign acc  = start && !busy;

    // divider step on |sum|
    logic [SW-1:0] div_abs, div_trial_rem;
    logic [SW:0]   div_sub;
    logic [CW-1:0] div_den;
    logic          div_neg;
    always_comb begin
        div_neg = (r_state == ST_DIVX) ? r_sx[SW-1] : r_sy[SW-1];
        div_abs = (r_state == ST_DIVX) ? (r_sx[SW-1] ? -r_sx : r_sx)
                                       : (r_sy[SW-1] ? -r_sy : r_sy);
        div_den = r_cnt;
        div_trial_rem = {r_rem[SW-2:0], div_abs[r_bit]};
        div_sub = {1'b0, div_trial_rem} - {{(SW+1-CW){1'b0}}, div_den};
    end

    // compare: is new vertex v strictly before stored p
    logic [1:0] ca, cb;
    logic signed [2*OffW:0] xprod;
    logic less;
    always_comb begin
        ca = half_class(r_vx, r_vy);
        cb = half_class(r_px, r_py);
        xprod = (2*OffW+1)'(r_vx * r_py) - (2*OffW+1)'(r_vy * r_px);
        if (ca != cb) begin
            less = ca < cb;
        end else if (ca == HC_ZERO || ca == HC_180) begin
            less = 1'b0;
        end else begin
            less = xprod > 0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:     if (acc && i_final_vertex) n_state = ST_DIVX;
            ST_DIVX:     if (r_bit == 5'd0) n_state = ST_DIVY;
            ST_DIVY:     if (r_bit == 5'd0) n_state = ST_SORT_RD;
            ST_SORT_RD:  if (r_i == r_cnt) n_state = ST_EMIT;
                         else n_state = ST_SORT_CMP;
            ST_SORT_CMP: if (r_j == '0 || !less) n_state = ST_SORT_RD;
            ST_EMIT:     if (r_i == r_cnt - 1'b1) n_state = ST_LOAD;
            default:     n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc && r_cnt != CW'(MAX_VERTICES)) begin
            m_x[r_cnt[IW-1:0]] <= i_x_coord;
            m_y[r_cnt[IW-1:0]] <= i_y_coord;
        end
        if (r_state == ST_SORT_RD && r_i != r_cnt) begin
            r_vx <= OffW'(m_x[r_i[IW-1:0]]) - OffW'(r_cx);
            r_vy <= OffW'(m_y[r_i[IW-1:0]]) - OffW'(r_cy);
            if (r_i != '0) begin
                r_px <= s_x[IW'(r_i - 1'b1)];
                r_py <= s_y[IW'(r_i - 1'b1)];
            end
        end
        if (r_state == ST_SORT_CMP) begin
            if (r_j != '0 && less) begin
                s_x[r_j[IW-1:0]] <= r_px;
                s_y[r_j[IW-1:0]] <= r_py;
                if (r_j != CW'(1)) begin
                    r_px <= s_x[IW'(r_j - 2'd2)];
                    r_py <= s_y[IW'(r_j - 2'd2)];
                end
            end else begin
                s_x[r_j[IW-1:0]] <= r_vx;
                s_y[r_j[IW-1:0]] <= r_vy;
            end
        end
        if (r_state == ST_EMIT) begin
            o_x_offset <= s_x[r_i[IW-1:0]];
            o_y_offset <= s_y[r_i[IW-1:0]];
            o_last_out <= (r_i == r_cnt - 1'b1);
            o_overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_ovf   <= 1'b0;
            r_bit   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            o_valid <= 1'b0;
            r_quo   <= '0;
            r_rem   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == ST_EMIT);
            case (r_state)
                ST_LOAD: begin
                    r_bit <= 5'(SW - 1);
                    r_rem <= '0;
                    r_i   <= '0;
                    if (acc) begin
                        if (r_cnt != CW'(MAX_VERTICES)) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_sx  <= r_sx + SW'(i_x_coord);
                            r_sy  <= r_sy + SW'(i_y_coord);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_DIVX, ST_DIVY: begin
                    if (!div_sub[SW]) begin
                        r_rem <= div_sub[SW-1:0];
                        r_quo <= {r_quo[SW-2:0], 1'b1};
                    end else begin
                        r_rem <= div_trial_rem;
                        r_quo <= {r_quo[SW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 5'd0) begin
                        r_bit <= 5'(SW - 1);
                        r_rem <= '0;
                        if (r_state == ST_DIVX) begin
                            r_cx <= div_neg ? -16'({r_quo[14:0], ~div_sub[SW]})
                                            : 16'({r_quo[14:0], ~div_sub[SW]});
                        end else begin
                            r_cy <= div_neg ? -16'({r_quo[14:0], ~div_sub[SW]})
                                            : 16'({r_quo[14:0], ~div_sub[SW]});
                        end
                    end
                end
                ST_SORT_RD: begin
                    r_j <= r_i;
                    if (r_i == r_cnt) r_i <= '0;
                end
                ST_SORT_CMP: begin
                    if (r_j != '0 && less) begin
                        r_j <= r_j - 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_EMIT: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == r_cnt - 1'b1) begin
                        r_cnt <= '0;
                        r_sx  <= '0;
                        r_sy  <= '0;
                        r_ovf <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // store count never exceeds capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_VERTICES)) else $error("count above capacity");
    // a result never goes out while the block is idle, but for the last word of a run
    a_no_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && !$past(r_state == ST_EMIT)) |-> !o_valid)
        else $error("stray output");
    // last word returns to load
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |-> r_state == ST_LOAD)
        else $error("last word without return to idle");
endmodule
